>>> hdl/cva_pkg.sv
package cva_pkg;

    // ADC and fixed-point format
    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 8;
    localparam int SCALE_SH  = 16 - FRAC_BITS;   // Q8.16 gain product down to Q.FRAC_BITS

    // field widths
    localparam int IN_W   = 12;
    localparam int CUR_W  = 32;
    localparam int VH_W   = 20;
    localparam int GAIN_W = 24;
    localparam int CNT_W  = 8;
    localparam int ZO_W   = 13;
    localparam int VAL_W  = 32;

    localparam int S_TDATA_W = ((3 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CUR_W + VH_W + 7) / 8) * 8;

    // clamp difference: (clamp - ref) - zero_offset
    localparam int D_W = (((ADC_BITS + 1) > ZO_W) ? (ADC_BITS + 1) : ZO_W) + 1;

    // shared serial unit
    localparam int MA_W   = 32;
    localparam int MB_W   = GAIN_W;
    localparam int ACC_W  = MA_W + MB_W;
    localparam int DIV_W  = 41;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [CNT_W-1:0] VOLT_SCALE = CNT_W'(100);
    localparam logic [VH_W-1:0]  VH_MAX     = '1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COUNT  = 3'd4;

    typedef enum logic {
        SU_MUL,
        SU_DIV
    } t_su_op;

    typedef struct packed {
        logic              start;
        t_su_op            op;
        logic [DIV_W-1:0]  opa;     // multiplicand or dividend
        logic [MB_W-1:0]   opb;     // multiplier, MSB aligned, or divisor in low bits
        logic [STEP_W-1:0] steps;
    } t_su_cmd;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] result;
    } t_su_rsp;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MUL_X,
        PH_MUL_I,
        PH_DIV_I,
        PH_MUL_O,
        PH_DIV_O,
        PH_MUL_V,
        PH_MUL_VA,
        PH_DIV_V,
        PH_MUL_H,
        PH_EMIT
    } t_phase;

    // sign-magnitude to saturated signed 32
    function automatic logic [VAL_W-1:0] f_sat_s32(input logic neg,
                                                   input logic [DIV_W-1:0] mag);
        logic [VAL_W-1:0] res;
        if (!neg) begin
            res = (mag > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[VAL_W-1:0];
        end else begin
            res = (mag > DIV_W'(32'h8000_0000)) ? 32'h8000_0000
                                                : (~mag[VAL_W-1:0] + 32'd1);
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] f_sat_u32(input logic [DIV_W-1:0] mag);
        logic [VAL_W-1:0] res;
        res = (mag > DIV_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : mag[VAL_W-1:0];
        return res;
    endfunction

endpackage

>>> hdl/cva_serial.sv
module cva_serial import cva_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_su_cmd i_cmd,
    output t_su_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_su_op            r_op;
    logic [MA_W-1:0]   r_a;
    logic [MB_W-1:0]   r_b;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_rem;

    logic [ACC_W-1:0]  n_acc;
    logic [MB_W-1:0]   n_b;
    logic [CNT_W-1:0]  n_rem;
    logic [CNT_W:0]    w_trial;
    logic              w_ge;

    // one multiplier bit (MSB first) or one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_acc[DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_b[CNT_W-1:0]});
        n_acc   = r_acc;
        n_b     = r_b;
        n_rem   = r_rem;
        unique case (r_op)
            SU_MUL: begin
                n_acc = {r_acc[ACC_W-2:0], 1'b0}
                      + (r_b[MB_W-1] ? {{MB_W{1'b0}}, r_a} : '0);
                n_b   = {r_b[MB_W-2:0], 1'b0};
            end
            SU_DIV: begin
                n_rem = w_ge ? CNT_W'(w_trial - {1'b0, r_b[CNT_W-1:0]}) : w_trial[CNT_W-1:0];
                n_acc = {r_acc[ACC_W-1:DIV_W], r_acc[DIV_W-2:0], w_ge};
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= SU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
                r_op   <= i_cmd.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a   <= i_cmd.opa[MA_W-1:0];
            r_b   <= i_cmd.opb;
            r_rem <= '0;
            r_acc <= (i_cmd.op == SU_DIV) ? {{(ACC_W-DIV_W){1'b0}}, i_cmd.opa} : '0;
        end else if (r_busy) begin
            r_a   <= r_a;
            r_b   <= n_b;
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("serial unit restarted while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("serial unit done while still busy");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == SU_DIV) |-> (r_rem < r_b[CNT_W-1:0]))
        else $error("partial remainder not below divisor");

endmodule

>>> hdl/current_voltage_averager_core.sv
// Cascaded moving-average filter for a current clamp and a voltage. Each input
// item carries a clamp sample, its reference and a voltage sample. The scaled clamp
// difference feeds an inner average over inner_count items; at the end of each inner
// run the inner value feeds an outer average and the scaled voltage feeds a voltage
// average, and after outer_count inner runs one result item (current in Q.8, voltage
// in hundredths) is sent and the outer average restarts from zero. All products and
// divisions go one bit per cycle through a single shared shift-add / restoring-divide
// unit, and the 41-step divisions dominate the time an item takes. The input is taken
// only while no item is in flight; a finished result waits in the output register
// while the next items are taken.
module current_voltage_averager_core import cva_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [11:0] clamp_sample, [23:12] clamp_reference, [35:24] voltage_sample
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [31:0] current_value, [51:32] voltage_hundredths
    output logic [M_TDATA_W-1:0] o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [GAIN_W-1:0]    i_cfg_wdata
);

    // configuration
    logic signed [ZO_W-1:0] r_zo;
    logic [GAIN_W-1:0]      r_cgain;
    logic [GAIN_W-1:0]      r_vgain;
    logic [CNT_W-1:0]       r_ncnt;
    logic [CNT_W-1:0]       r_mcnt;

    // filter state
    logic [VAL_W-1:0]       r_inner;
    logic [VAL_W-1:0]       r_outer;
    logic [VAL_W-1:0]       r_vavg;
    logic [CNT_W-1:0]       r_inner_idx;
    logic [CNT_W-1:0]       r_outer_idx;
    logic                   r_run_end;
    logic                   r_meas_end;

    // sequencer
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic                   r_go;
    logic                   n_go;

    // scratch
    logic signed [D_W-1:0]  r_d;
    logic [ADC_BITS-1:0]    r_volt;
    logic [VAL_W-1:0]       r_x;
    logic [VAL_W-1:0]       r_v;
    logic [DIV_W-1:0]       r_sum_mag;
    logic                   r_mneg;
    logic [VH_W-1:0]        r_h;

    // output register
    logic                   r_out_valid;
    logic [CUR_W-1:0]       r_out_cur;
    logic [VH_W-1:0]        r_out_vh;

    t_su_cmd                w_cmd;
    t_su_rsp                w_rsp;
    logic                   w_cmd_neg;
    logic                   w_load_out;
    logic                   w_s_acc;
    logic                   w_slot_free;

    logic [CNT_W-1:0]       w_n;
    logic [CNT_W-1:0]       w_m;
    logic [CNT_W-1:0]       w_in_next;
    logic [CNT_W-1:0]       w_out_next;
    logic                   w_run_end;
    logic                   w_meas_end;

    logic [ADC_BITS-1:0]    w_clamp;
    logic [ADC_BITS-1:0]    w_cref;
    logic signed [D_W-1:0]  w_d;
    logic [D_W-1:0]         w_d_mag;
    logic [VAL_W-1:0]       w_inner_mag;
    logic [VAL_W-1:0]       w_outer_mag;

    logic signed [DIV_W+1:0] w_prod;
    logic signed [DIV_W+1:0] w_term;
    logic signed [DIV_W+1:0] w_addend;
    logic signed [DIV_W+1:0] w_sum;
    logic [DIV_W+1:0]        w_sum_abs;
    logic [ACC_W-1:0]        w_scaled;
    logic [ACC_W-1:0]        w_hmag;

    cva_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    // a count of zero acts as one
    assign w_n = (r_ncnt == '0) ? CNT_W'(1) : r_ncnt;
    assign w_m = (r_mcnt == '0) ? CNT_W'(1) : r_mcnt;

    assign o_s_tready  = (r_phase == PH_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_valid || i_m_tready;

    assign w_clamp = ADC_BITS'(i_s_tdata[IN_W-1:0]);
    assign w_cref  = ADC_BITS'(i_s_tdata[2*IN_W-1:IN_W]);
    assign w_d     = $signed({{(D_W-ADC_BITS){1'b0}}, w_clamp})
                   - $signed({{(D_W-ADC_BITS){1'b0}}, w_cref})
                   - $signed({{(D_W-ZO_W){r_zo[ZO_W-1]}}, r_zo});

    // run bookkeeping is settled when the item is taken
    assign w_in_next  = r_inner_idx + 1'b1;
    assign w_run_end  = !((w_in_next < w_n) && (w_in_next != '0));
    assign w_out_next = r_outer_idx + 1'b1;
    assign w_meas_end = w_run_end && !((w_out_next < w_m) && (w_out_next != '0));

    assign w_d_mag     = r_d[D_W-1] ? D_W'(-r_d) : D_W'(r_d);
    assign w_inner_mag = r_inner[VAL_W-1] ? (~r_inner + 1'b1) : r_inner;
    assign w_outer_mag = r_outer[VAL_W-1] ? (~r_outer + 1'b1) : r_outer;

    // (N-1)*prev with its sign, plus the new term
    always_comb begin
        w_prod = $signed({2'b00, w_rsp.result[DIV_W-1:0]});
        w_term = r_mneg ? -w_prod : w_prod;
        case (r_phase)
            PH_MUL_I: w_addend = $signed({{(DIV_W+2-VAL_W){r_x[VAL_W-1]}}, r_x});
            PH_MUL_O: w_addend = $signed({{(DIV_W+2-VAL_W){r_inner[VAL_W-1]}}, r_inner});
            default:  w_addend = $signed({{(DIV_W+2-VAL_W){1'b0}}, r_v});
        endcase
        w_sum     = w_term + w_addend;
        w_sum_abs = w_sum[DIV_W+1] ? (DIV_W+2)'(-w_sum) : (DIV_W+2)'(w_sum);
    end

    assign w_scaled = w_rsp.result >> SCALE_SH;
    assign w_hmag   = w_rsp.result >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_go    <= n_go;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_go       = 1'b0;
        w_cmd      = '0;
        w_cmd.op   = SU_MUL;
        w_cmd_neg  = 1'b0;
        w_load_out = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_s_acc) begin
                    n_phase = PH_MUL_X;
                    n_go    = 1'b1;
                end
            end
            PH_MUL_X: begin
                w_cmd.opa   = DIV_W'(w_d_mag);
                w_cmd.opb   = r_cgain;
                w_cmd.steps = STEP_W'(GAIN_W);
                w_cmd_neg   = r_d[D_W-1];
                if (w_rsp.done) begin
                    n_phase = PH_MUL_I;
                    n_go    = 1'b1;
                end
            end
            PH_MUL_I: begin
                w_cmd.opa   = DIV_W'(w_inner_mag);
                w_cmd.opb   = {w_n - 1'b1, {(MB_W-CNT_W){1'b0}}};
                w_cmd.steps = STEP_W'(CNT_W);
                w_cmd_neg   = r_inner[VAL_W-1];
                if (w_rsp.done) begin
                    n_phase = PH_DIV_I;
                    n_go    = 1'b1;
                end
            end
            PH_DIV_I: begin
                w_cmd.op    = SU_DIV;
                w_cmd.opa   = r_sum_mag;
                w_cmd.opb   = MB_W'(w_n);
                w_cmd.steps = STEP_W'(DIV_W);
                if (w_rsp.done) begin
                    n_phase = r_run_end ? PH_MUL_O : PH_IDLE;
                    n_go    = r_run_end;
                end
            end
            PH_MUL_O: begin
                w_cmd.opa   = DIV_W'(w_outer_mag);
                w_cmd.opb   = {w_m - 1'b1, {(MB_W-CNT_W){1'b0}}};
                w_cmd.steps = STEP_W'(CNT_W);
                w_cmd_neg   = r_outer[VAL_W-1];
                if (w_rsp.done) begin
                    n_phase = PH_DIV_O;
                    n_go    = 1'b1;
                end
            end
            PH_DIV_O: begin
                w_cmd.op    = SU_DIV;
                w_cmd.opa   = r_sum_mag;
                w_cmd.opb   = MB_W'(w_m);
                w_cmd.steps = STEP_W'(DIV_W);
                if (w_rsp.done) begin
                    n_phase = PH_MUL_V;
                    n_go    = 1'b1;
                end
            end
            PH_MUL_V: begin
                w_cmd.opa   = DIV_W'(r_volt);
                w_cmd.opb   = r_vgain;
                w_cmd.steps = STEP_W'(GAIN_W);
                if (w_rsp.done) begin
                    n_phase = PH_MUL_VA;
                    n_go    = 1'b1;
                end
            end
            PH_MUL_VA: begin
                w_cmd.opa   = DIV_W'(r_vavg);
                w_cmd.opb   = {w_n - 1'b1, {(MB_W-CNT_W){1'b0}}};
                w_cmd.steps = STEP_W'(CNT_W);
                if (w_rsp.done) begin
                    n_phase = PH_DIV_V;
                    n_go    = 1'b1;
                end
            end
            PH_DIV_V: begin
                w_cmd.op    = SU_DIV;
                w_cmd.opa   = r_sum_mag;
                w_cmd.opb   = MB_W'(w_n);
                w_cmd.steps = STEP_W'(DIV_W);
                if (w_rsp.done) begin
                    n_phase = r_meas_end ? PH_MUL_H : PH_IDLE;
                    n_go    = r_meas_end;
                end
            end
            PH_MUL_H: begin
                w_cmd.opa   = DIV_W'(r_vavg);
                w_cmd.opb   = {VOLT_SCALE, {(MB_W-CNT_W){1'b0}}};
                w_cmd.steps = STEP_W'(CNT_W);
                if (w_rsp.done) begin
                    n_phase = PH_EMIT;
                end
            end
            PH_EMIT: begin
                if (w_slot_free) begin
                    w_load_out = 1'b1;
                    n_phase    = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        w_cmd.start = r_go && (r_phase != PH_IDLE) && (r_phase != PH_EMIT);
    end

    // configuration, filter state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zo        <= '0;
            r_cgain     <= GAIN_W'(65536);
            r_vgain     <= GAIN_W'(65536);
            r_ncnt      <= CNT_W'(20);
            r_mcnt      <= CNT_W'(10);
            r_inner     <= '0;
            r_outer     <= '0;
            r_vavg      <= '0;
            r_inner_idx <= '0;
            r_outer_idx <= '0;
            r_run_end   <= 1'b0;
            r_meas_end  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ZERO_OFFSET:  r_zo    <= $signed(i_cfg_wdata[ZO_W-1:0]);
                    CFG_CLAMP_GAIN:   r_cgain <= i_cfg_wdata;
                    CFG_VOLTAGE_GAIN: r_vgain <= i_cfg_wdata;
                    CFG_INNER_COUNT:  r_ncnt  <= i_cfg_wdata[CNT_W-1:0];
                    CFG_OUTER_COUNT:  r_mcnt  <= i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (w_s_acc) begin
                r_run_end   <= w_run_end;
                r_meas_end  <= w_meas_end;
                r_inner_idx <= w_run_end ? '0 : w_in_next;
                if (w_run_end) begin
                    r_outer_idx <= w_meas_end ? '0 : w_out_next;
                end
            end
            if (w_rsp.done) begin
                case (r_phase)
                    PH_DIV_I: r_inner <= f_sat_s32(r_mneg, w_rsp.result[DIV_W-1:0]);
                    PH_DIV_O: r_outer <= f_sat_s32(r_mneg, w_rsp.result[DIV_W-1:0]);
                    PH_DIV_V: r_vavg  <= f_sat_u32(w_rsp.result[DIV_W-1:0]);
                    default: ;
                endcase
            end
            if (w_load_out) begin
                r_outer     <= '0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scratch and output payload
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_d    <= w_d;
            r_volt <= ADC_BITS'(i_s_tdata[3*IN_W-1:2*IN_W]);
        end
        if (w_cmd.start && w_cmd.op == SU_MUL) begin
            r_mneg <= w_cmd_neg;
        end
        if (w_rsp.done) begin
            case (r_phase)
                PH_MUL_X: r_x <= f_sat_s32(r_mneg, w_scaled[DIV_W-1:0]);
                PH_MUL_I, PH_MUL_O, PH_MUL_VA: begin
                    r_sum_mag <= w_sum_abs[DIV_W-1:0];
                    r_mneg    <= w_sum[DIV_W+1];
                end
                PH_MUL_V: r_v <= f_sat_u32(w_scaled[DIV_W-1:0]);
                PH_MUL_H: r_h <= (w_hmag > ACC_W'(VH_MAX)) ? VH_MAX : w_hmag[VH_W-1:0];
                default: ;
            endcase
        end
        if (w_load_out) begin
            r_out_cur <= r_outer;
            r_out_vh  <= r_h;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-CUR_W-VH_W){1'b0}}, r_out_vh, r_out_cur};

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_phase) == PH_EMIT))
        else $error("result raised outside the emit step");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_phase != PH_IDLE && r_phase != PH_EMIT))
        else $error("serial unit finished with no operation pending");

    a_meas_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_meas_end) |-> r_run_end)
        else $error("measurement end without inner run end");

endmodule
